[src/drt_pkg.sv]
// Package for the DLCI route table: sizes, request codes and shared types.
// Used by drt_direct_valid, drt_ctrl, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package drt_pkg;

    localparam int CAPACITY     = 256;
    localparam int DIRECT_DEPTH = 1024;
    localparam int KEY_W        = 23;
    localparam int HANDLE_W     = 16;
    localparam int DIR_AW       = $clog2(DIRECT_DEPTH);
    localparam int SORT_AW      = $clog2(CAPACITY);
    localparam int CNT_W        = SORT_AW + 1;
    localparam int SORT_W       = KEY_W + HANDLE_W;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [KEY_W-1:0]    dlci_key;
        logic [HANDLE_W-1:0] entry_handle;
    } drt_req_t;

    typedef struct packed {
        logic                ok;
        logic [HANDLE_W-1:0] found_handle;
    } drt_rsp_t;

endpackage

[src/drt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for both route tables.
`timescale 1ns / 1ps

module drt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/drt_direct_valid.sv]
// Valid bits of the direct table, held in a RAM that a pass after reset clears.
// Depends on drt_pkg and drt_ram.
`timescale 1ns / 1ps

module drt_direct_valid
    import drt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [DIR_AW-1:0] addr,
    input  logic              wbit,
    output logic              rbit,
    output logic              busy
);

    logic [DIR_AW-1:0] clr_addr_reg, clr_addr_next;
    logic              busy_reg, busy_next;
    logic              ram_we;
    logic [DIR_AW-1:0] ram_waddr;
    logic              ram_wdata;

    assign busy = busy_reg;

    // Clearing pass: one entry per cycle until the whole table is zero.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == DIR_AW'(DIRECT_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Set on add, clear on delete; the clearing pass owns the write port first.
    assign ram_we    = busy_reg | we;
    assign ram_waddr = busy_reg ? clr_addr_reg : addr;
    assign ram_wdata = busy_reg ? 1'b0 : wbit;

    drt_ram #(.WIDTH(1), .DEPTH(DIRECT_DEPTH)) u_valid_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(addr),
        .rdata(rbit)
    );

endmodule

[src/drt_ctrl.sv]
// Request sequencer: direct access, binary search and shift passes.
// Depends on drt_pkg; drives the ports of both table memories.
`timescale 1ns / 1ps

module drt_ctrl
    import drt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                direct_mode,
    input  logic                req_valid,
    output logic                req_ready,
    input  drt_req_t            req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output drt_rsp_t            rsp,
    // direct table
    output logic                dir_we,
    output logic [DIR_AW-1:0]   dir_addr,
    output logic [HANDLE_W-1:0] dir_wdata,
    input  logic [HANDLE_W-1:0] dir_rdata,
    output logic                dv_we,
    output logic                dv_wbit,
    input  logic                dv_rbit,
    input  logic                dv_busy,
    // sorted table
    output logic                srt_we,
    output logic [SORT_AW-1:0]  srt_waddr,
    output logic [SORT_W-1:0]   srt_wdata,
    output logic [SORT_AW-1:0]  srt_raddr,
    input  logic [SORT_W-1:0]   srt_rdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DREAD  = 3'd1;
    localparam logic [2:0] ST_SREAD  = 3'd2;
    localparam logic [2:0] ST_SCMP   = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_SHWR   = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    logic [2:0]          state_reg, state_next;
    drt_req_t            req_reg;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                hit_reg, hit_next;
    drt_rsp_t            rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [KEY_W-1:0]    rd_key;
    logic [HANDLE_W-1:0] rd_hnd;
    logic                key_small;
    logic [CNT_W-1:0]    mid_calc;

    assign rd_key    = srt_rdata[SORT_W-1:HANDLE_W];
    assign rd_hnd    = srt_rdata[HANDLE_W-1:0];
    assign key_small = (req_reg.dlci_key[KEY_W-1:DIR_AW] == '0);
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign req_ready = (state_reg == ST_IDLE) && !rsp_valid_reg && !dv_busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    // The direct read is issued at acceptance so its data is ready in ST_DREAD.
    assign dir_addr  = (state_reg == ST_IDLE) ? req.dlci_key[DIR_AW-1:0]
                                              : req_reg.dlci_key[DIR_AW-1:0];
    assign dir_wdata = req_reg.entry_handle;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        dir_we         = 1'b0;
        dv_we          = 1'b0;
        dv_wbit        = 1'b0;
        srt_we         = 1'b0;
        srt_waddr      = idx_reg[SORT_AW-1:0];
        srt_wdata      = {req_reg.dlci_key, req_reg.entry_handle};
        srt_raddr      = mid_calc[SORT_AW-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    lo_next  = '0;
                    hi_next  = count_reg;
                    hit_next = 1'b0;
                    rsp_next = '0;
                    if (req.req_type != REQ_LOOKUP && req.req_type != REQ_ADD
                        && req.req_type != REQ_DELETE)
                    begin
                        state_next = ST_RESP;
                    end
                    else if (direct_mode)
                    begin
                        state_next = ST_DREAD;
                    end
                    else
                    begin
                        state_next = ST_SREAD;
                    end
                end
            end
            ST_DREAD:
            begin
                // Table data for the key, read at acceptance, is now valid.
                state_next = ST_RESP;
                if (key_small)
                begin
                    rsp_next.ok = 1'b1;
                    unique case (req_reg.req_type)
                        REQ_LOOKUP:
                        begin
                            rsp_next.ok = dv_rbit;
                            rsp_next.found_handle = dv_rbit ? dir_rdata : '0;
                        end
                        REQ_ADD:
                        begin
                            dir_we  = 1'b1;
                            dv_we   = 1'b1;
                            dv_wbit = 1'b1;
                        end
                        default:
                        begin
                            dv_we = 1'b1;
                        end
                    endcase
                end
            end
            ST_SREAD:
            begin
                // Issue read at the midpoint, or end the search.
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_SCMP;
                end
                else
                begin
                    mid_next = lo_reg;
                    state_next = ST_SCMP;
                    hit_next = 1'b0;
                    // No read needed: decide on miss directly.
                    unique case (req_reg.req_type)
                        REQ_ADD:
                        begin
                            if (count_reg[CNT_W-1])
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = ST_SHIFT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCMP:
            begin
                if (rd_key == req_reg.dlci_key)
                begin
                    hit_next = 1'b1;
                    unique case (req_reg.req_type)
                        REQ_LOOKUP:
                        begin
                            rsp_next.ok = 1'b1;
                            rsp_next.found_handle = rd_hnd;
                            state_next = ST_RESP;
                        end
                        REQ_ADD:
                        begin
                            srt_we     = 1'b1;
                            srt_waddr  = mid_reg[SORT_AW-1:0];
                            rsp_next.ok = 1'b1;
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            idx_next   = mid_reg;
                            state_next = ST_SHIFT;
                        end
                    endcase
                end
                else
                begin
                    if (rd_key < req_reg.dlci_key)
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = ST_SREAD;
                end
            end
            ST_SHIFT:
            begin
                // Read the neighbor to move, or finish the pass.
                if (hit_reg)
                begin
                    // Delete: move idx+1 down to idx.
                    if (idx_reg + 1'b1 < count_reg)
                    begin
                        srt_raddr  = idx_reg[SORT_AW-1:0] + 1'b1;
                        state_next = ST_SHWR;
                    end
                    else
                    begin
                        count_next  = count_reg - 1'b1;
                        rsp_next.ok = 1'b1;
                        state_next  = ST_RESP;
                    end
                end
                else
                begin
                    // Insert: move idx-1 up to idx, then place key at lo.
                    if (idx_reg > lo_reg)
                    begin
                        srt_raddr  = idx_reg[SORT_AW-1:0] - 1'b1;
                        state_next = ST_SHWR;
                    end
                    else
                    begin
                        srt_we      = 1'b1;
                        count_next  = count_reg + 1'b1;
                        rsp_next.ok = 1'b1;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_SHWR:
            begin
                srt_we     = 1'b1;
                srt_wdata  = srt_rdata;
                idx_next   = hit_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                state_next = ST_SHIFT;
            end
            ST_RESP:
            begin
                rsp_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end

endmodule

[src/dlci_route_table_core.sv]
// Top level of the DLCI route table: ports, mode register, table memories.
// Depends on drt_pkg, drt_ctrl, drt_direct_valid and drt_ram.
`timescale 1ns / 1ps

// One item at a time. After reset the input stays closed while a clearing pass
// zeroes the valid bits of the direct table. A direct-mode item passes through
// ST_DREAD and ST_RESP before its result is offered. A sorted-mode lookup is
// bounded by the single read port of the sorted memory: each binary search probe
// issues a read at the midpoint (ST_SREAD) and compares it (ST_SCMP). A hit ends
// at the compare, a miss when the range is empty; a full table of 256 keys takes
// at most nine probes. An insert or a delete then moves each entry with a read
// (ST_SHIFT) and a write (ST_SHWR). The next item is taken the cycle after the
// previous result has been delivered.
module dlci_route_table_core
    import drt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [39:0] s_tdata,   // dlci_key[22:0], entry_handle[38:23], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // ok[0], found_handle[16:1], zero pad
);

    logic                direct_mode_reg;
    drt_req_t            req;
    drt_rsp_t            rsp;
    logic                dir_we, dv_we, dv_wbit, dv_rbit, dv_busy, srt_we;
    logic [DIR_AW-1:0]   dir_addr;
    logic [HANDLE_W-1:0] dir_wdata, dir_rdata;
    logic [SORT_AW-1:0]  srt_waddr, srt_raddr;
    logic [SORT_W-1:0]   srt_wdata, srt_rdata;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            direct_mode_reg <= cfg_wdata;
        end
    end

    assign req.req_type     = s_tuser;
    assign req.dlci_key     = s_tdata[KEY_W-1:0];
    assign req.entry_handle = s_tdata[KEY_W+HANDLE_W-1:KEY_W];
    assign m_tdata          = {7'd0, rsp.found_handle, rsp.ok};

    drt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .direct_mode(direct_mode_reg),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .rsp_valid  (m_tvalid),
        .rsp_ready  (m_tready),
        .rsp        (rsp),
        .dir_we     (dir_we),
        .dir_addr   (dir_addr),
        .dir_wdata  (dir_wdata),
        .dir_rdata  (dir_rdata),
        .dv_we      (dv_we),
        .dv_wbit    (dv_wbit),
        .dv_rbit    (dv_rbit),
        .dv_busy    (dv_busy),
        .srt_we     (srt_we),
        .srt_waddr  (srt_waddr),
        .srt_wdata  (srt_wdata),
        .srt_raddr  (srt_raddr),
        .srt_rdata  (srt_rdata)
    );

    drt_direct_valid u_dvalid (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (dv_we),
        .addr (dir_addr),
        .wbit (dv_wbit),
        .rbit (dv_rbit),
        .busy (dv_busy)
    );

    drt_ram #(.WIDTH(HANDLE_W), .DEPTH(DIRECT_DEPTH)) u_dir_ram (
        .clk  (clk),
        .we   (dir_we),
        .waddr(dir_addr),
        .wdata(dir_wdata),
        .raddr(dir_addr),
        .rdata(dir_rdata)
    );

    drt_ram #(.WIDTH(SORT_W), .DEPTH(CAPACITY)) u_srt_ram (
        .clk  (clk),
        .we   (srt_we),
        .waddr(srt_waddr),
        .wdata(srt_wdata),
        .raddr(srt_raddr),
        .rdata(srt_rdata)
    );

endmodule

[src/drt_checker.sv]
// Port-level checks of the DLCI route table, bound to the top level.
// Depends on dlci_route_table_core.
`timescale 1ns / 1ps

module drt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A miss or failure never carries a handle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("handle on a failed result");

    // Pad bits of the result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:17] == 7'd0)
        else $error("nonzero result padding");

    // An accepted item closes input until its result appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // Input is never open while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input open with result pending");

endmodule

bind dlci_route_table_core drt_checker u_drt_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

[verif/drt_route_checker.sv]
// Checker for the DLCI route table: watches request, response and register writes,
// predicts each response from a private copy of both tables and compares it.
// Depends on drt_pkg.
`timescale 1ns / 1ps

module drt_route_checker
    import drt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [39:0] s_tdata,   // dlci_key[22:0], entry_handle[38:23], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // ok[0], found_handle[16:1], zero pad
    output int          pending,
    output int          fail_count
);

    // Private copy of the mode register and both tables.
    logic                mode_direct;
    logic                dir_valid  [DIRECT_DEPTH];
    logic [HANDLE_W-1:0] dir_handle [DIRECT_DEPTH];
    logic [KEY_W-1:0]    sort_key   [CAPACITY];
    logic [HANDLE_W-1:0] sort_handle[CAPACITY];
    int                  sort_count;

    // Responses predicted but not yet seen on the output.
    drt_rsp_t            rsp_q[$];

    initial
    begin
        mode_direct = 1'b1;
        sort_count  = 0;
        pending     = 0;
        fail_count  = 0;
        for (int i = 0; i < DIRECT_DEPTH; i++)
        begin
            dir_valid[i]  = 1'b0;
            dir_handle[i] = '0;
        end
    end

    // Apply one request to the private tables and return the response it gives.
    function automatic drt_rsp_t route_request(logic [1:0] req, logic [KEY_W-1:0] key,
                                               logic [HANDLE_W-1:0] hnd);
        drt_rsp_t rsp;
        int       lo;
        int       hi;
        int       mid;
        bit       hit;
        rsp = '0;
        lo  = 0;
        hi  = sort_count;
        hit = 0;
        if (req == REQ_LOOKUP || req == REQ_ADD || req == REQ_DELETE)
        begin
            if (mode_direct)
            begin
                // Keys of 1024 and up never reach the direct table.
                if (key < DIRECT_DEPTH)
                begin
                    if (req == REQ_LOOKUP)
                    begin
                        if (dir_valid[key])
                        begin
                            rsp.ok           = 1'b1;
                            rsp.found_handle = dir_handle[key];
                        end
                    end
                    else if (req == REQ_ADD)
                    begin
                        dir_valid[key]  = 1'b1;
                        dir_handle[key] = hnd;
                        rsp.ok          = 1'b1;
                    end
                    else
                    begin
                        dir_valid[key] = 1'b0;
                        rsp.ok         = 1'b1;
                    end
                end
            end
            else
            begin
                // Binary search; on a miss lo is the insertion point.
                while (lo < hi && !hit)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (sort_key[mid] == key)
                    begin
                        hit = 1;
                        lo  = mid;
                    end
                    else if (sort_key[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (req == REQ_LOOKUP)
                begin
                    if (hit)
                    begin
                        rsp.ok           = 1'b1;
                        rsp.found_handle = sort_handle[lo];
                    end
                end
                else if (req == REQ_ADD)
                begin
                    if (hit)
                    begin
                        sort_handle[lo] = hnd;
                        rsp.ok          = 1'b1;
                    end
                    else if (sort_count < CAPACITY)
                    begin
                        for (int i = sort_count; i > lo; i--)
                        begin
                            sort_key[i]    = sort_key[i-1];
                            sort_handle[i] = sort_handle[i-1];
                        end
                        sort_key[lo]    = key;
                        sort_handle[lo] = hnd;
                        sort_count++;
                        rsp.ok = 1'b1;
                    end
                end
                else if (hit)
                begin
                    for (int i = lo; i + 1 < sort_count; i++)
                    begin
                        sort_key[i]    = sort_key[i+1];
                        sort_handle[i] = sort_handle[i+1];
                    end
                    sort_count--;
                    rsp.ok = 1'b1;
                end
            end
        end
        return rsp;
    endfunction

    // Predict on each accepted request with the mode in force, then track register
    // writes, and check each response.
    always @(posedge clk)
    begin
        drt_rsp_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                rsp_q.push_back(route_request(s_tuser, s_tdata[22:0], s_tdata[38:23]));
            if (cfg_we)
                mode_direct = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (rsp_q.size() == 0)
                begin
                    $display("%0t: response with none outstanding: ok %0b handle %h",
                             $time, m_tdata[0], m_tdata[16:1]);
                    fail_count++;
                end
                else
                begin
                    want = rsp_q.pop_front();
                    if (m_tdata[0] !== want.ok)
                    begin
                        $display("%0t: ok mismatch: expected %0b, actual %0b",
                                 $time, want.ok, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[16:1] !== want.found_handle)
                    begin
                        $display("%0t: found_handle mismatch: expected %h, actual %h",
                                 $time, want.found_handle, m_tdata[16:1]);
                        fail_count++;
                    end
                end
            end
            pending = rsp_q.size();
        end
    end

endmodule

[verif/tb_dlci_route_table_core.sv]
// Testbench top for the DLCI route table: clock, reset, request stimulus in
// both modes, response back-pressure and the verdict. Depends on drt_pkg,
// dlci_route_table_core and drt_route_checker.
`timescale 1ns / 1ps

module tb_dlci_route_table_core;
    import drt_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // req_type
    logic [39:0] s_tdata;   // dlci_key[22:0], entry_handle[38:23], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // ok[0], found_handle[16:1], zero pad
    int          pending;
    int          fail_count;
    logic        s_fire;
    logic        hold_off;
    int          burst_left;

    dlci_route_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    drt_route_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Remember whether the request item was taken at the last rising edge.
    always @(posedge clk)
        s_fire <= s_tvalid && s_tready;

    // Receiver: a stall pattern drawn at random from three styles; hold_off overrides it.
    always @(negedge clk)
    begin
        int cyc;
        int style;
        cyc = int'($time / 10);
        if (cyc % 64 == 0)
            style = $urandom_range(0, 2);
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else if (style == 0)
            m_tready <= 1'b1;
        else if (style == 1)
            m_tready <= ($urandom_range(0, 1) == 1);
        else
            m_tready <= ($urandom_range(0, 3) == 0);
    end

    // One long receiver hold-off after the clearing pass, while requests keep coming.
    initial
    begin
        hold_off = 1'b0;
        repeat (2000) @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offer one request item and return at the falling edge after it is taken.
    // Items go out in bursts with random gaps in between.
    task automatic send_req(logic [1:0] req, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hnd);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, hnd, key};
        do
            @(negedge clk);
        while (!s_fire);
    endtask

    // Let all outstanding responses drain, then write the mode register.
    task automatic set_mode(logic direct);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= direct;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [1:0] pick_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return REQ_LOOKUP;
        else if (r < 75)
            return REQ_ADD;
        else if (r < 95)
            return REQ_DELETE;
        return REQ_UNKNOWN;
    endfunction

    initial
    begin
        logic [KEY_W-1:0] key;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = '0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        burst_left = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Direct table: edges of the key range, overwrite, absent delete, bad code.
        set_mode(1'b1);
        send_req(REQ_LOOKUP, 23'd0, 16'hFFFF);
        send_req(REQ_ADD, 23'd0, 16'hFFFF);
        send_req(REQ_ADD, 23'd1023, 16'h0001);
        send_req(REQ_LOOKUP, 23'd0, 16'h0000);
        send_req(REQ_LOOKUP, 23'd1023, 16'h0000);
        send_req(REQ_ADD, 23'd1023, 16'hA5A5);
        send_req(REQ_LOOKUP, 23'd1023, 16'h0000);
        send_req(REQ_ADD, 23'd1024, 16'h1234);
        send_req(REQ_LOOKUP, 23'd1024, 16'h0000);
        send_req(REQ_DELETE, 23'h7FFFFF, 16'h0000);
        send_req(REQ_DELETE, 23'd500, 16'h0000);
        send_req(REQ_UNKNOWN, 23'd0, 16'hFFFF);
        send_req(REQ_DELETE, 23'd0, 16'h0000);
        send_req(REQ_LOOKUP, 23'd0, 16'h0000);

        // Random direct traffic, mostly inside the table.
        for (int n = 0; n < 150; n++)
        begin
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 1023));
            send_req(pick_req(), key, HANDLE_W'($urandom));
        end

        // Sorted table: empty lookup, unordered inserts, overwrite, misses and hits.
        set_mode(1'b0);
        send_req(REQ_LOOKUP, 23'd5, 16'h0000);
        send_req(REQ_DELETE, 23'd5, 16'h0000);
        send_req(REQ_ADD, 23'd50, 16'h0050);
        send_req(REQ_ADD, 23'd10, 16'h0010);
        send_req(REQ_ADD, 23'h7FFFFF, 16'hFFFF);
        send_req(REQ_ADD, 23'd0, 16'h0000);
        send_req(REQ_ADD, 23'd30, 16'h0030);
        send_req(REQ_ADD, 23'd10, 16'hBEEF);
        send_req(REQ_LOOKUP, 23'd10, 16'h0000);
        send_req(REQ_LOOKUP, 23'h7FFFFF, 16'h0000);
        send_req(REQ_LOOKUP, 23'd20, 16'h0000);
        send_req(REQ_DELETE, 23'd20, 16'h0000);
        send_req(REQ_DELETE, 23'd30, 16'h0000);
        send_req(REQ_LOOKUP, 23'd30, 16'h0000);
        send_req(REQ_UNKNOWN, 23'd50, 16'h0000);

        // Random sorted traffic over a small key pool so hits are common.
        for (int n = 0; n < 200; n++)
        begin
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 95));
            send_req(pick_req(), key, HANDLE_W'($urandom));
        end

        // Fill to capacity with ascending keys, then overflow, overwrite, delete.
        send_req(REQ_DELETE, 23'h7FFFFF, 16'h0000);
        for (int n = 0; n < 270; n++)
            send_req(REQ_ADD, KEY_W'(23'h100000 + n), HANDLE_W'($urandom));
        send_req(REQ_ADD, 23'd7, 16'h7777);
        send_req(REQ_ADD, 23'h100000, 16'h1111);
        send_req(REQ_LOOKUP, 23'h100000, 16'h0000);
        send_req(REQ_DELETE, 23'h100005, 16'h0000);
        send_req(REQ_ADD, 23'd7, 16'h7777);
        for (int n = 0; n < 40; n++)
            send_req($urandom_range(0, 1) ? REQ_LOOKUP : REQ_DELETE,
                     KEY_W'(23'h100000 + $urandom_range(0, 300)), HANDLE_W'($urandom));

        // Back to direct: its contents must have survived the sorted phase.
        set_mode(1'b1);
        for (int n = 0; n < 80; n++)
            send_req(pick_req(), KEY_W'($urandom_range(0, 1100)), HANDLE_W'($urandom));

        // And the sorted table must still hold what was left in it.
        set_mode(1'b0);
        for (int n = 0; n < 60; n++)
            send_req($urandom_range(0, 3) == 0 ? REQ_ADD : REQ_LOOKUP,
                     KEY_W'(23'h100000 + $urandom_range(0, 300)), HANDLE_W'($urandom));

        // Drain and settle before the verdict.
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
